// ----- rtl/kmdl_pkg.sv -----
package kmdl_pkg;

   // operation codes carried on the request tuser
   localparam logic [1:0] OP_SCAN         = 2'd0;
   localparam logic [1:0] OP_SET_LAYER    = 2'd1;
   localparam logic [1:0] OP_TOGGLE_LAYER = 2'd2;
   localparam logic [1:0] OP_WRITE_MAP    = 2'd3;

   // control register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_TICKS     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS = 1'd1;
   localparam int unsigned CSR_DATA_W = 16;

   // fixed field widths
   localparam int unsigned KEY_FIELD_W   = 6;
   localparam int unsigned LAYER_FIELD_W = 4;
   localparam int unsigned CODE_W        = 8;
   localparam int unsigned COUNT_W       = 16;
   localparam int unsigned TICKS_W       = 8;
   localparam int unsigned ENTRY_W       = CODE_W + 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_KEY,
      ST_WALK
   } state_type;

   // result of one debounce update
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               stable;
      logic               toggled;
   } deb_res_type;

endpackage

// ----- rtl/key_matrix_debounce_layer_resolve.sv -----
// key matrix debounce with layered keymap lookup
//
// request channel (req_*): one operation per request, selected by req_tuser.
//   scan key: debounce the raw level of one key and resolve its keycode.
//   set layer / toggle layer: change a layer's active flag (layer 0 stays on).
//   write keymap: store one 9-bit keymap entry for a layer and key.
// response channel (rsp_*): one response per scan of an in-range key, none
//   for the other operations or for out-of-range keys.
// control port (csr_*): scan_ticks at index 0, debounce_ticks at index 1, to be
//   written only while no request is in flight; the user must ensure this, as
//   the block itself does not enforce it.
// layer and keymap requests finish in the cycle they are accepted. a scan
//   first updates the key's counter, then walks from the highest layer down
//   through the single keymap read port, one layer per cycle, ending at the
//   first active layer with an entry, or after layer 0 with a zero keycode.
// one request at a time: req_tready is low from the scan accept until its
//   response is taken; a stalled rsp_tready holds the response and the block.
// reset: only layer 0 active. a clearing pass then zeroes the keymap, one entry
//   per cycle over 2^(clog2(NUM_LAYERS) + clog2(NUM_KEYS)) entries (1024 at the
//   defaults), clearing all counters and releasing all keys, with req_tready low.
module key_matrix_debounce_layer_resolve
   import kmdl_pkg::*;
#(
   parameter int unsigned NUM_KEYS   = 64,
   parameter int unsigned NUM_LAYERS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // key_index[5:0], raw_pressed[6], layer[10:7], layer_active[11],
   // map_keycode[19:12], map_is_custom[20], zero fill[23:21]
   input  logic [23:0]           req_tdata,
   // operation[1:0]
   input  logic [1:0]            req_tuser,
   // last_of_scan
   input  logic                  req_tlast,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // key_out[5:0], resolved_keycode[13:6], resolved_custom[14],
   // stable_pressed_out[15], state_change[16], report_pressed[17], zero fill[23:18]
   output logic [23:0]           rsp_tdata,
   // end_of_scan
   output logic                  rsp_tlast,
   // control registers
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // address widths
   localparam int unsigned KW        = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int unsigned LW        = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
   localparam int unsigned MAP_AW    = LW + KW;
   localparam int unsigned KEY_DEPTH = 1 << KW;
   localparam int unsigned MAP_DEPTH = 1 << MAP_AW;
   localparam int unsigned KEY_WORD  = COUNT_W + 1;

   localparam logic [8:0]    NUM_KEYS_V  = 9'(NUM_KEYS);
   localparam logic [5:0]    NUM_LAYER_V = 6'(NUM_LAYERS);
   localparam logic [LW-1:0] TOP_LAYER   = LW'(NUM_LAYERS - 1);

   // request fields
   logic [KEY_FIELD_W-1:0]   req_key;
   logic                     req_raw;
   logic [LAYER_FIELD_W-1:0] req_layer;
   logic                     req_active;
   logic [CODE_W-1:0]        req_code;
   logic                     req_custom;
   logic [1:0]               req_op;

   assign req_key    = req_tdata[5:0];
   assign req_raw    = req_tdata[6];
   assign req_layer  = req_tdata[10:7];
   assign req_active = req_tdata[11];
   assign req_code   = req_tdata[19:12];
   assign req_custom = req_tdata[20];
   assign req_op     = req_tuser;

   logic [8:0]    req_key_ext;
   logic [5:0]    req_layer_ext;
   logic [KW-1:0] req_key_idx;
   logic [LW-1:0] req_layer_idx;
   logic          key_ok;
   logic          layer_ok;

   assign req_key_ext   = {3'b000, req_key};
   assign req_layer_ext = {2'b00, req_layer};
   assign req_key_idx   = req_key_ext[KW-1:0];
   assign req_layer_idx = req_layer_ext[LW-1:0];
   assign key_ok        = req_key_ext < NUM_KEYS_V;
   assign layer_ok      = req_layer_ext < NUM_LAYER_V;

   // control state
   state_type           state_ff, state_in;
   logic [MAP_AW-1:0]   clr_ff, clr_in;
   logic [NUM_LAYERS-1:0] layer_en_ff, layer_en_in;
   logic [LW-1:0]       walk_ff, walk_in;
   logic                iss_ff, iss_in;
   logic                chk_vld_ff, chk_vld_in;
   logic                chk_en_ff, chk_en_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [TICKS_W-1:0]  scan_ticks_ff, scan_ticks_in;
   logic [COUNT_W-1:0]  dbn_ticks_ff, dbn_ticks_in;

   // payload
   logic [KW-1:0]       key_idx_ff;
   logic [KEY_FIELD_W-1:0] key_out_ff;
   logic                raw_ff;
   logic                last_ff;
   logic                stable_ff;
   logic                event_ff;
   logic [CODE_W-1:0]   res_code_ff;
   logic                res_cust_ff;

   // memories
   logic [KEY_WORD-1:0] key_mem [KEY_DEPTH];
   logic [ENTRY_W-1:0]  map_mem [MAP_DEPTH];
   logic [KEY_WORD-1:0] key_rd_ff;
   logic [ENTRY_W-1:0]  map_rd_ff;

   // handshakes
   logic req_acc;
   logic scan_start;
   logic walk_done;
   logic entry_hit;
   logic hit_now;

   assign req_acc    = req_tvalid && req_tready;
   assign scan_start = req_acc && (req_op == OP_SCAN) && key_ok;
   assign entry_hit  = map_rd_ff[CODE_W] || (map_rd_ff[CODE_W-1:0] != '0);
   assign hit_now    = chk_vld_ff && chk_en_ff && entry_hit;
   assign walk_done  = (state_ff == ST_WALK) && (hit_now || !iss_ff);

   // shared debounce update
   deb_res_type deb_res;

   kmdl_debounce u_debounce (
      .count          (key_rd_ff[COUNT_W-1:0]),
      .stable         (key_rd_ff[COUNT_W]),
      .raw            (raw_ff),
      .scan_ticks     (scan_ticks_ff),
      .debounce_ticks (dbn_ticks_ff),
      .res            (deb_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == {MAP_AW{1'b1}}) state_in = ST_IDLE;
         ST_IDLE:  if (scan_start) state_in = ST_KEY;
         ST_KEY:   state_in = ST_WALK;
         ST_WALK:  if (walk_done) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // memory write controls
   logic                key_we;
   logic [KW-1:0]       key_waddr;
   logic [KEY_WORD-1:0] key_wdata;
   logic                map_we;
   logic [MAP_AW-1:0]   map_waddr;
   logic [ENTRY_W-1:0]  map_wdata;
   logic [KW-1:0]       key_raddr;
   logic [MAP_AW-1:0]   map_raddr;

   assign key_raddr = req_key_idx;
   assign map_raddr = {walk_ff, key_idx_ff};

   // outputs and sequencer controls
   always_comb begin
      req_tready  = 1'b0;
      key_we      = 1'b0;
      key_waddr   = key_idx_ff;
      key_wdata   = {deb_res.stable, deb_res.count};
      map_we      = 1'b0;
      map_waddr   = {req_layer_idx, req_key_idx};
      map_wdata   = {req_custom, req_code};
      layer_en_in = layer_en_ff;
      clr_in      = clr_ff;
      walk_in     = walk_ff;
      iss_in      = iss_ff;
      chk_vld_in  = 1'b0;
      chk_en_in   = chk_en_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            // zero the keymap and the key counters in one sweep
            clr_in    = clr_ff + MAP_AW'(1);
            map_we    = 1'b1;
            map_waddr = clr_ff;
            map_wdata = '0;
            key_we    = 1'b1;
            key_waddr = clr_ff[KW-1:0];
            key_wdata = '0;
         end
         ST_IDLE: begin
            req_tready = !rsp_vld_ff;
            if (req_acc) begin
               unique case (req_op)
                  OP_SET_LAYER: begin
                     if (layer_ok && req_layer != '0) begin
                        layer_en_in[req_layer_idx] = req_active;
                     end
                  end
                  OP_TOGGLE_LAYER: begin
                     if (layer_ok && req_layer != '0) begin
                        layer_en_in[req_layer_idx] = ~layer_en_ff[req_layer_idx];
                     end
                  end
                  OP_WRITE_MAP: begin
                     map_we = layer_ok && key_ok;
                  end
                  OP_SCAN: begin
                     // counter read is issued here, handled in ST_KEY
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_KEY: begin
            key_we  = 1'b1;
            walk_in = TOP_LAYER;
            iss_in  = 1'b1;
         end
         ST_WALK: begin
            // issue one layer read per cycle, check the previous one
            if (iss_ff) begin
               chk_vld_in = 1'b1;
               chk_en_in  = layer_en_ff[walk_ff];
               if (walk_ff == '0) begin
                  iss_in = 1'b0;
               end else begin
                  walk_in = walk_ff - LW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_vld_ff && rsp_tready) rsp_vld_in = 1'b0;
      if (walk_done) rsp_vld_in = 1'b1;
   end

   // control registers
   always_comb begin
      scan_ticks_in = scan_ticks_ff;
      dbn_ticks_in  = dbn_ticks_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            CSR_SCAN_TICKS:     scan_ticks_in = csr_wdata[TICKS_W-1:0];
            CSR_DEBOUNCE_TICKS: dbn_ticks_in  = csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         layer_en_ff   <= NUM_LAYERS'(1);
         walk_ff       <= '0;
         iss_ff        <= 1'b0;
         chk_vld_ff    <= 1'b0;
         chk_en_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         scan_ticks_ff <= TICKS_W'(1);
         dbn_ticks_ff  <= COUNT_W'(5);
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         layer_en_ff   <= layer_en_in;
         walk_ff       <= walk_in;
         iss_ff        <= iss_in;
         chk_vld_ff    <= chk_vld_in;
         chk_en_ff     <= chk_en_in;
         rsp_vld_ff    <= rsp_vld_in;
         scan_ticks_ff <= scan_ticks_in;
         dbn_ticks_ff  <= dbn_ticks_in;
      end
   end

   // scan payload
   always_ff @(posedge clock) begin
      if (scan_start) begin
         key_idx_ff <= req_key_idx;
         key_out_ff <= req_key;
         raw_ff     <= req_raw;
         last_ff    <= req_tlast;
      end
      if (state_ff == ST_KEY) begin
         stable_ff <= deb_res.stable;
         event_ff  <= deb_res.toggled;
      end
      if (walk_done) begin
         res_code_ff <= hit_now ? map_rd_ff[CODE_W-1:0] : '0;
         res_cust_ff <= hit_now ? map_rd_ff[CODE_W] : 1'b0;
      end
   end

   // key state memory: debounced level over counter
   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_waddr] <= key_wdata;
      key_rd_ff <= key_mem[key_raddr];
   end

   // keymap memory, addressed by layer over key
   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_waddr] <= map_wdata;
      map_rd_ff <= map_mem[map_raddr];
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {6'b000000,
                        ~res_cust_ff & stable_ff,
                        event_ff,
                        stable_ff,
                        res_cust_ff,
                        res_code_ff,
                        key_out_ff};

   // checks
   a_ready_excl_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request taken while a response is pending");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken during keymap clearing");

   a_layer0_on: assert property (@(posedge clock) disable iff (reset)
      layer_en_ff[0])
      else $error("layer 0 went inactive");

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && !iss_ff) |=> (state_ff == ST_IDLE && rsp_vld_ff))
      else $error("layer walk did not end with a response");

endmodule

// ----- rtl/kmdl_debounce.sv -----
module kmdl_debounce
   import kmdl_pkg::*;
(
   input  logic [COUNT_W-1:0] count,
   input  logic               stable,
   input  logic               raw,
   input  logic [TICKS_W-1:0] scan_ticks,
   input  logic [COUNT_W-1:0] debounce_ticks,
   output deb_res_type        res
);

   logic [COUNT_W:0]   sum;
   logic [COUNT_W-1:0] sum_sat;

   assign sum     = {1'b0, count} + (COUNT_W+1)'(scan_ticks);
   assign sum_sat = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];

   always_comb begin
      res.count   = count;
      res.stable  = stable;
      res.toggled = 1'b0;
      if (raw != stable) begin
         if (sum_sat >= debounce_ticks) begin
            res.count   = '0;
            res.stable  = ~stable;
            res.toggled = 1'b1;
         end else begin
            res.count = sum_sat;
         end
      end
   end

endmodule
